/* rtl/core/pwlcm_pkg.sv */
package pwlcm_pkg;

    // field widths of the transaction payloads
    localparam int POS_W   = 32;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 4;
    localparam int RGBA_W  = NUM_CH * CH_W;
    localparam int ENTRY_W = POS_W + RGBA_W;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 4;
    localparam int SEG_W   = 4;
    localparam int STAT_W  = 2;

    // interpolation arithmetic
    localparam int FRAC_W = 16;
    localparam int DEN_W  = POS_W + 1;
    localparam int NUM_W  = DEN_W + FRAC_W;
    localparam int QBITS  = 25;
    localparam int W2_W   = QBITS + 2;
    localparam int DIFF_W = CH_W + 1;
    localparam int PROD_W = W2_W + DIFF_W;
    localparam int CTR_W  = $clog2(QBITS);

    // weight clamp: beyond this any nonzero color step saturates
    localparam logic signed [W2_W-1:0]   W2_LIMIT = W2_W'(64'd1 << QBITS);
    localparam logic signed [PROD_W-1:0] ROUND    = PROD_W'(64'd1 << (FRAC_W - 1));
    localparam logic signed [PROD_W-1:0] CH_MAX   = PROD_W'((64'd1 << CH_W) - 64'd1);

    // request types
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FEW_POINTS = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ZERO_WIDTH = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        point_index;
        logic signed [POS_W-1:0] sample_value;
        logic [CH_W-1:0]         in_red;
        logic [CH_W-1:0]         in_green;
        logic [CH_W-1:0]         in_blue;
        logic [CH_W-1:0]         in_alpha;
    } req_item_t;

    typedef struct packed {
        logic [CH_W-1:0]   out_red;
        logic [CH_W-1:0]   out_green;
        logic [CH_W-1:0]   out_blue;
        logic [CH_W-1:0]   out_alpha;
        logic [SEG_W-1:0]  segment_upper;
        logic [STAT_W-1:0] status;
    } rsp_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_CHECK,
        ST_DIV,
        ST_FIX,
        ST_MUL,
        ST_MIX,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              accept;
        logic              res_zero;
        logic [STAT_W-1:0] res_status;
        logic              rd_first;
        logic              rd_next;
        logic              scan_step;
        logic              seg_latch;
        logic              prep;
        logic              check;
        logic              div_step;
        logic              fix;
        logic              mul;
        logic              mix;
        logic              emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_lookup;
        logic few_points;
        logic pos_ge;
        logic first;
        logic last;
        logic hit0;
        logic den_zero;
        logic rsp_free;
    } dp_stat_t;

endpackage

/* rtl/core/piecewise_linear_color_map_core.sv */
// Piecewise-linear color map. A table of up to MAX_POINTS control points, each a signed
// Q16.16 position and an RGBA8 color, maps a Q16.16 sample to a color. Every request
// transaction (write or lookup) returns exactly one response transaction; writes and errors
// return zero color with a status. Only one request is in flight at a time. In a regular
// lookup, k (2 up to the number of points in use) is the number of table entries the scan
// reads through the single table read port until it finds the segment; a one-bit-per-cycle
// divider then forms the segment weight. A lookup that lands on a zero-width segment ends
// after the scan, without the divider. While the output register is full and stalled,
// the next response waits before it is loaded. The response sits in an output register,
// so the next request is taken as soon as the response is loaded. The user must write
// num_points through the cfg channel only while no request is in flight; the block itself
// does not enforce it; table entries must be written before a lookup reads them.
module piecewise_linear_color_map_core #(
    parameter int MAX_POINTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  pwlcm_pkg::req_item_t        req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output pwlcm_pkg::rsp_item_t        rsp_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pwlcm_pkg::CNT_W-1:0] cfg_data
);

    pwlcm_pkg::dp_cmd_t  cmd;
    pwlcm_pkg::dp_stat_t stat;

    // sequencer
    pwlcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table, divider, blend and output register
    pwlcm_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* rtl/core/pwlcm_ram.sv */
module pwlcm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/pwlcm_ctrl.sv */
module pwlcm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  pwlcm_pkg::dp_stat_t stat,
    output pwlcm_pkg::dp_cmd_t  cmd
);

    pwlcm_pkg::state_t state_reg;
    pwlcm_pkg::state_t state_next;
    logic [pwlcm_pkg::CTR_W-1:0] div_cnt_reg;
    logic [pwlcm_pkg::CTR_W-1:0] div_cnt_next;
    logic scan_stop;
    logic div_last;

    // scan ends at the first qualifying point, or at the last point in use
    assign scan_stop = !stat.first && (stat.hit0 || stat.pos_ge || stat.last);
    assign div_last  = (div_cnt_reg == pwlcm_pkg::CTR_W'(pwlcm_pkg::QBITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pwlcm_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // division step counter
    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        if (state_reg == pwlcm_pkg::ST_CHECK)
        begin
            div_cnt_next = '0;
        end
        else if (state_reg == pwlcm_pkg::ST_DIV)
        begin
            div_cnt_next = div_cnt_reg + pwlcm_pkg::CTR_W'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pwlcm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (!stat.is_lookup || stat.few_points)
                    begin
                        state_next = pwlcm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = pwlcm_pkg::ST_SCAN;
                    end
                end
            end
            pwlcm_pkg::ST_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = pwlcm_pkg::ST_PREP;
                end
            end
            pwlcm_pkg::ST_PREP:
            begin
                state_next = pwlcm_pkg::ST_CHECK;
            end
            pwlcm_pkg::ST_CHECK:
            begin
                state_next = stat.den_zero ? pwlcm_pkg::ST_EMIT : pwlcm_pkg::ST_DIV;
            end
            pwlcm_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = pwlcm_pkg::ST_FIX;
                end
            end
            pwlcm_pkg::ST_FIX:
            begin
                state_next = pwlcm_pkg::ST_MUL;
            end
            pwlcm_pkg::ST_MUL:
            begin
                state_next = pwlcm_pkg::ST_MIX;
            end
            pwlcm_pkg::ST_MIX:
            begin
                state_next = pwlcm_pkg::ST_EMIT;
            end
            pwlcm_pkg::ST_EMIT:
            begin
                if (stat.rsp_free)
                begin
                    state_next = pwlcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwlcm_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd       = '0;
        req_stall = (state_reg != pwlcm_pkg::ST_IDLE);
        unique case (state_reg)
            pwlcm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!stat.is_lookup)
                    begin
                        cmd.res_zero   = 1'b1;
                        cmd.res_status = pwlcm_pkg::STATUS_OK;
                    end
                    else if (stat.few_points)
                    begin
                        cmd.res_zero   = 1'b1;
                        cmd.res_status = pwlcm_pkg::STATUS_FEW_POINTS;
                    end
                    else
                    begin
                        cmd.rd_first = 1'b1;
                    end
                end
            end
            pwlcm_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (scan_stop)
                begin
                    cmd.seg_latch = 1'b1;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            pwlcm_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            pwlcm_pkg::ST_CHECK:
            begin
                if (stat.den_zero)
                begin
                    cmd.res_zero   = 1'b1;
                    cmd.res_status = pwlcm_pkg::STATUS_ZERO_WIDTH;
                end
                else
                begin
                    cmd.check = 1'b1;
                end
            end
            pwlcm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            pwlcm_pkg::ST_FIX:
            begin
                cmd.fix = 1'b1;
            end
            pwlcm_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            pwlcm_pkg::ST_MIX:
            begin
                cmd.mix = 1'b1;
            end
            pwlcm_pkg::ST_EMIT:
            begin
                cmd.emit = stat.rsp_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/pwlcm_dp.sv */
module pwlcm_dp #(
    parameter int MAX_POINTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pwlcm_pkg::req_item_t          req_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pwlcm_pkg::CNT_W-1:0]   cfg_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output pwlcm_pkg::rsp_item_t          rsp_data,
    input  pwlcm_pkg::dp_cmd_t            cmd,
    output pwlcm_pkg::dp_stat_t           stat
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = (NW > pwlcm_pkg::CNT_W) ? NW : pwlcm_pkg::CNT_W;

    // configuration
    logic [pwlcm_pkg::CNT_W-1:0] num_points_reg;
    logic [CW-1:0] n_full;
    logic [CW-1:0] n_max;
    logic [CW-1:0] n_use;

    // table access
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [pwlcm_pkg::ENTRY_W-1:0]  ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [pwlcm_pkg::ENTRY_W-1:0]  ram_rdata;

    // scan state
    logic signed [pwlcm_pkg::POS_W-1:0] sample_reg;
    logic [AW-1:0]                      chk_idx_reg;
    logic [pwlcm_pkg::ENTRY_W-1:0]      prev_entry_reg;
    logic                               hit0_reg;
    logic signed [pwlcm_pkg::POS_W-1:0] rd_pos;

    // segment
    logic [pwlcm_pkg::ENTRY_W-1:0] lo_entry_reg;
    logic [pwlcm_pkg::ENTRY_W-1:0] hi_entry_reg;
    logic [AW-1:0]                 up_idx_reg;

    // division
    logic signed [pwlcm_pkg::DEN_W-1:0] vdiff;
    logic signed [pwlcm_pkg::DEN_W-1:0] den;
    logic signed [pwlcm_pkg::NUM_W-1:0] num_s;
    logic [pwlcm_pkg::NUM_W-1:0]        num_mag_reg;
    logic [pwlcm_pkg::DEN_W-1:0]        den_mag_reg;
    logic                               neg_reg;
    logic                               den_zero_reg;
    logic                               ovf_reg;
    logic [pwlcm_pkg::DEN_W-1:0]        rem_reg;
    logic [pwlcm_pkg::QBITS-1:0]        quo_reg;
    logic [pwlcm_pkg::DEN_W:0]          div_shifted;
    logic                               div_ge;

    // weight and blend
    logic signed [pwlcm_pkg::W2_W-1:0]   qm_s;
    logic signed [pwlcm_pkg::W2_W-1:0]   w2_val;
    logic signed [pwlcm_pkg::W2_W-1:0]   w2_reg;
    logic signed [pwlcm_pkg::DIFF_W-1:0] ch_diff [pwlcm_pkg::NUM_CH];
    logic signed [pwlcm_pkg::PROD_W-1:0] prod_reg [pwlcm_pkg::NUM_CH];
    logic signed [pwlcm_pkg::PROD_W-1:0] ch_round [pwlcm_pkg::NUM_CH];
    logic signed [pwlcm_pkg::PROD_W-1:0] ch_sum [pwlcm_pkg::NUM_CH];
    logic [pwlcm_pkg::CH_W-1:0]          ch_sat [pwlcm_pkg::NUM_CH];

    // result and output register
    pwlcm_pkg::rsp_item_t res_reg;
    pwlcm_pkg::rsp_item_t rsp_data_reg;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    // configuration write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_points_reg <= cfg_data;
        end
    end

    // points in use, capped at the table depth
    always_comb
    begin
        n_full = CW'(num_points_reg);
        n_max  = CW'(MAX_POINTS);
        n_use  = (n_full < n_max) ? n_full : n_max;
    end

    // control point table: position low, rgba high
    assign ram_we    = cmd.accept && (req_data.req_type == pwlcm_pkg::REQ_WRITE) &&
                       (32'(req_data.point_index) < 32'(MAX_POINTS));
    assign ram_waddr = AW'(req_data.point_index);
    assign ram_wdata = {req_data.in_alpha, req_data.in_blue, req_data.in_green,
                        req_data.in_red, req_data.sample_value};
    assign ram_re    = cmd.rd_first || cmd.rd_next;
    assign ram_raddr = cmd.rd_first ? '0 : (chk_idx_reg + AW'(1));

    pwlcm_ram #(
        .WIDTH (pwlcm_pkg::ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_pos = signed'(ram_rdata[pwlcm_pkg::POS_W-1:0]);

    // segment setup arithmetic
    always_comb
    begin
        vdiff = pwlcm_pkg::DEN_W'(sample_reg) -
                pwlcm_pkg::DEN_W'(signed'(lo_entry_reg[pwlcm_pkg::POS_W-1:0]));
        den   = pwlcm_pkg::DEN_W'(signed'(hi_entry_reg[pwlcm_pkg::POS_W-1:0])) -
                pwlcm_pkg::DEN_W'(signed'(lo_entry_reg[pwlcm_pkg::POS_W-1:0]));
        num_s = signed'({vdiff, {pwlcm_pkg::FRAC_W{1'b0}}});
    end

    // restoring division step, one quotient bit per cycle
    always_comb
    begin
        div_shifted = {rem_reg, quo_reg[pwlcm_pkg::QBITS-1]};
        div_ge      = (div_shifted >= {1'b0, den_mag_reg});
    end

    // floor-signed weight, clamped where every nonzero step saturates anyway
    always_comb
    begin
        qm_s = signed'(pwlcm_pkg::W2_W'(quo_reg));
        if (ovf_reg)
        begin
            w2_val = neg_reg ? -pwlcm_pkg::W2_LIMIT : pwlcm_pkg::W2_LIMIT;
        end
        else if (neg_reg)
        begin
            w2_val = -qm_s - signed'(pwlcm_pkg::W2_W'(rem_reg != '0));
        end
        else
        begin
            w2_val = qm_s;
        end
    end

    // per channel: c = lc + round(w2 * (uc - lc) / 65536), saturated
    always_comb
    begin
        for (int i = 0; i < pwlcm_pkg::NUM_CH; i++)
        begin
            ch_diff[i] =
                signed'(pwlcm_pkg::DIFF_W'(hi_entry_reg[pwlcm_pkg::POS_W + i*pwlcm_pkg::CH_W +:
                                                        pwlcm_pkg::CH_W])) -
                signed'(pwlcm_pkg::DIFF_W'(lo_entry_reg[pwlcm_pkg::POS_W + i*pwlcm_pkg::CH_W +:
                                                        pwlcm_pkg::CH_W]));
            ch_round[i] = (prod_reg[i] + pwlcm_pkg::ROUND) >>> pwlcm_pkg::FRAC_W;
            ch_sum[i]   = ch_round[i] +
                signed'(pwlcm_pkg::PROD_W'(lo_entry_reg[pwlcm_pkg::POS_W + i*pwlcm_pkg::CH_W +:
                                                        pwlcm_pkg::CH_W]));
            if (ch_sum[i] < 0)
            begin
                ch_sat[i] = '0;
            end
            else if (ch_sum[i] > pwlcm_pkg::CH_MAX)
            begin
                ch_sat[i] = '1;
            end
            else
            begin
                ch_sat[i] = ch_sum[i][pwlcm_pkg::CH_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= req_data.sample_value;
        end
        if (ram_re)
        begin
            chk_idx_reg <= ram_raddr;
        end
        if (cmd.scan_step)
        begin
            prev_entry_reg <= ram_rdata;
            if (chk_idx_reg == '0)
            begin
                hit0_reg <= (rd_pos >= sample_reg);
            end
        end
        if (cmd.seg_latch)
        begin
            lo_entry_reg <= prev_entry_reg;
            hi_entry_reg <= ram_rdata;
            up_idx_reg   <= chk_idx_reg;
        end
        if (cmd.prep)
        begin
            num_mag_reg  <= num_s[pwlcm_pkg::NUM_W-1] ? unsigned'(-num_s) : unsigned'(num_s);
            den_mag_reg  <= den[pwlcm_pkg::DEN_W-1] ? unsigned'(-den) : unsigned'(den);
            neg_reg      <= vdiff[pwlcm_pkg::DEN_W-1] ^ den[pwlcm_pkg::DEN_W-1];
            den_zero_reg <= (den == '0);
        end
        if (cmd.check)
        begin
            ovf_reg <= ((pwlcm_pkg::DEN_W + pwlcm_pkg::QBITS)'(num_mag_reg) >=
                        {den_mag_reg, {pwlcm_pkg::QBITS{1'b0}}});
            rem_reg <= pwlcm_pkg::DEN_W'(num_mag_reg >> pwlcm_pkg::QBITS);
            quo_reg <= num_mag_reg[pwlcm_pkg::QBITS-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? pwlcm_pkg::DEN_W'(div_shifted - {1'b0, den_mag_reg})
                              : pwlcm_pkg::DEN_W'(div_shifted);
            quo_reg <= {quo_reg[pwlcm_pkg::QBITS-2:0], div_ge};
        end
        if (cmd.fix)
        begin
            w2_reg <= w2_val;
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < pwlcm_pkg::NUM_CH; i++)
            begin
                prod_reg[i] <= pwlcm_pkg::PROD_W'(w2_reg) * pwlcm_pkg::PROD_W'(ch_diff[i]);
            end
        end
        if (cmd.res_zero)
        begin
            res_reg.out_red       <= '0;
            res_reg.out_green     <= '0;
            res_reg.out_blue      <= '0;
            res_reg.out_alpha     <= '0;
            res_reg.segment_upper <= '0;
            res_reg.status        <= cmd.res_status;
        end
        else if (cmd.mix)
        begin
            res_reg.out_red       <= ch_sat[0];
            res_reg.out_green     <= ch_sat[1];
            res_reg.out_blue      <= ch_sat[2];
            res_reg.out_alpha     <= ch_sat[3];
            res_reg.segment_upper <= pwlcm_pkg::SEG_W'(up_idx_reg);
            res_reg.status        <= pwlcm_pkg::STATUS_OK;
        end
        if (cmd.emit)
        begin
            rsp_data_reg <= res_reg;
        end
    end

    // output register valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // status to the controller
    always_comb
    begin
        stat.is_lookup  = (req_data.req_type == pwlcm_pkg::REQ_LOOKUP);
        stat.few_points = (n_use < CW'(2));
        stat.pos_ge     = (rd_pos >= sample_reg);
        stat.first      = (chk_idx_reg == '0);
        stat.last       = (CW'(chk_idx_reg) == (n_use - CW'(1)));
        stat.hit0       = hit0_reg;
        stat.den_zero   = den_zero_reg;
        stat.rsp_free   = !rsp_valid_reg || !rsp_stall;
    end

endmodule
